[src/cpu8eu_pkg.sv]
package cpu8eu_pkg;

	// status register bit positions
	localparam int FL_C = 0;
	localparam int FL_Z = 1;
	localparam int FL_I = 2;
	localparam int FL_D = 3;
	localparam int FL_B = 4;
	localparam int FL_U = 5;
	localparam int FL_V = 6;
	localparam int FL_N = 7;

	localparam int KIND_W = 6;
	localparam int BYTE_W = 8;
	localparam int IN_USER_W = KIND_W + 1;
	localparam int OUT_DATA_W = 56;

	// decoded operation codes; 52..63 are undefined
	typedef enum logic [KIND_W-1:0] {
		OP_ADC = 6'd0,  OP_SBC = 6'd1,  OP_AND = 6'd2,  OP_ORA = 6'd3,
		OP_EOR = 6'd4,  OP_ASL = 6'd5,  OP_LSR = 6'd6,  OP_ROL = 6'd7,
		OP_ROR = 6'd8,  OP_CMP = 6'd9,  OP_CPX = 6'd10, OP_CPY = 6'd11,
		OP_BIT = 6'd12, OP_INC = 6'd13, OP_DEC = 6'd14, OP_INX = 6'd15,
		OP_INY = 6'd16, OP_DEX = 6'd17, OP_DEY = 6'd18, OP_LDA = 6'd19,
		OP_LDX = 6'd20, OP_LDY = 6'd21, OP_STA = 6'd22, OP_STX = 6'd23,
		OP_STY = 6'd24, OP_TAX = 6'd25, OP_TAY = 6'd26, OP_TXA = 6'd27,
		OP_TYA = 6'd28, OP_TSX = 6'd29, OP_TXS = 6'd30, OP_CLC = 6'd31,
		OP_CLD = 6'd32, OP_CLI = 6'd33, OP_CLV = 6'd34, OP_SEC = 6'd35,
		OP_SED = 6'd36, OP_SEI = 6'd37, OP_PHA = 6'd38, OP_PHP = 6'd39,
		OP_PLA = 6'd40, OP_PLP = 6'd41, OP_BCC = 6'd42, OP_BCS = 6'd43,
		OP_BEQ = 6'd44, OP_BMI = 6'd45, OP_BNE = 6'd46, OP_BPL = 6'd47,
		OP_BVC = 6'd48, OP_BVS = 6'd49, OP_BRK = 6'd50, OP_NOP = 6'd51
	} kind_t;

	// architectural registers
	typedef struct packed {
		logic [BYTE_W-1:0] a;
		logic [BYTE_W-1:0] x;
		logic [BYTE_W-1:0] y;
		logic [BYTE_W-1:0] sp;
		logic [BYTE_W-1:0] p;
	} state_t;

	// per-item side results
	typedef struct packed {
		logic [BYTE_W-1:0] write_data;
		logic              write_enable;
		logic              branch_taken;
		logic              invalid_op;
	} result_t;

endpackage

[src/cpu8eu_datapath.sv]
module cpu8eu_datapath import cpu8eu_pkg::*; (
	input  logic [KIND_W-1:0] kind,
	input  logic [BYTE_W-1:0] operand,
	input  logic              on_memory,
	input  state_t            cur,
	output state_t            nxt,
	output result_t           res
);

	function automatic logic [BYTE_W-1:0] set_nz(input logic [BYTE_W-1:0] p,
			input logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] q;
		q = p;
		q[FL_Z] = (v == '0);
		q[FL_N] = v[7];
		return q;
	endfunction

	logic [BYTE_W-1:0] a, m, src, shr, idr;
	logic              c;
	logic [8:0]        adc_bin, sbc_bin, cmp_diff;
	logic [5:0]        dlo, dhi, dhi_f;
	logic [BYTE_W-1:0] dt;
	logic [4:0]        slo, shi;
	logic [3:0]        slo_f, shi_f;
	logic [BYTE_W-1:0] cmp_reg;

	assign a = cur.a;
	assign m = operand;
	assign c = cur.p[FL_C];
	assign src = on_memory ? m : a;

	// binary and decimal adders and subtractors
	always_comb begin
		adc_bin = {1'b0, a} + {1'b0, m} + {8'd0, c};
		dlo = {2'b0, a[3:0]} + {2'b0, m[3:0]} + {5'd0, c};
		if (dlo > 6'd9) begin
			dlo = dlo + 6'd6;
		end
		dhi = {2'b0, a[7:4]} + {2'b0, m[7:4]} + {5'd0, (dlo > 6'd15)};
		dt = {dhi[3:0], dlo[3:0]};
		dhi_f = (dhi > 6'd9) ? (dhi + 6'd6) : dhi;

		sbc_bin = {1'b0, a} + {1'b0, ~m} + {8'd0, c};
		slo = {1'b0, a[3:0]} - {1'b0, m[3:0]} - {4'd0, ~c};
		slo_f = slo[4] ? (slo[3:0] - 4'd6) : slo[3:0];
		shi = {1'b0, a[7:4]} - {1'b0, m[7:4]} - {4'd0, slo[4]};
		shi_f = shi[4] ? (shi[3:0] - 4'd6) : shi[3:0];
	end

	always_comb begin
		case (kind_t'(kind))
			OP_CPX:  cmp_reg = cur.x;
			OP_CPY:  cmp_reg = cur.y;
			default: cmp_reg = a;
		endcase
		cmp_diff = {1'b0, cmp_reg} - {1'b0, m};
	end

	// shifter and inc/dec on A or memory
	always_comb begin
		case (kind_t'(kind))
			OP_ASL:  shr = {src[6:0], 1'b0};
			OP_ROL:  shr = {src[6:0], c};
			OP_LSR:  shr = {1'b0, src[7:1]};
			default: shr = {c, src[7:1]};
		endcase
		idr = (kind_t'(kind) == OP_INC) ? (src + 8'd1) : (src - 8'd1);
	end

	always_comb begin
		nxt = cur;
		res = '0;
		case (kind_t'(kind))
			OP_ADC: begin
				nxt.p[FL_Z] = (adc_bin[7:0] == '0);
				if (cur.p[FL_D]) begin
					nxt.p[FL_N] = dt[7];
					nxt.p[FL_V] = ~(a[7] ^ m[7]) & (a[7] ^ dt[7]);
					nxt.p[FL_C] = (dhi_f > 6'd15);
					nxt.a = {dhi_f[3:0], dlo[3:0]};
				end else begin
					nxt.p[FL_N] = adc_bin[7];
					nxt.p[FL_V] = ~(a[7] ^ m[7]) & (a[7] ^ adc_bin[7]);
					nxt.p[FL_C] = adc_bin[8];
					nxt.a = adc_bin[7:0];
				end
			end
			OP_SBC: begin
				nxt.p[FL_C] = sbc_bin[8];
				nxt.p[FL_Z] = (sbc_bin[7:0] == '0);
				nxt.p[FL_V] = (a[7] ^ m[7]) & (a[7] ^ sbc_bin[7]);
				nxt.p[FL_N] = sbc_bin[7];
				nxt.a = cur.p[FL_D] ? {shi_f, slo_f} : sbc_bin[7:0];
			end
			OP_AND: begin
				nxt.a = a & m;
				nxt.p = set_nz(cur.p, a & m);
			end
			OP_ORA: begin
				nxt.a = a | m;
				nxt.p = set_nz(cur.p, a | m);
			end
			OP_EOR: begin
				nxt.a = a ^ m;
				nxt.p = set_nz(cur.p, a ^ m);
			end
			OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
				nxt.p = set_nz(cur.p, shr);
				nxt.p[FL_C] = (kind_t'(kind) == OP_ASL || kind_t'(kind) == OP_ROL)
					? src[7] : src[0];
				if (on_memory) begin
					res.write_data = shr;
					res.write_enable = 1'b1;
				end else begin
					nxt.a = shr;
				end
			end
			OP_CMP, OP_CPX, OP_CPY: begin
				nxt.p[FL_C] = ~cmp_diff[8];
				nxt.p[FL_Z] = (cmp_reg == m);
				nxt.p[FL_N] = cmp_diff[7];
			end
			OP_BIT: begin
				nxt.p[FL_Z] = ((a & m) == '0);
				nxt.p[FL_V] = m[6];
				nxt.p[FL_N] = m[7];
			end
			OP_INC, OP_DEC: begin
				nxt.p = set_nz(cur.p, idr);
				if (on_memory) begin
					res.write_data = idr;
					res.write_enable = 1'b1;
				end else begin
					nxt.a = idr;
				end
			end
			OP_INX: begin
				nxt.x = cur.x + 8'd1;
				nxt.p = set_nz(cur.p, cur.x + 8'd1);
			end
			OP_INY: begin
				nxt.y = cur.y + 8'd1;
				nxt.p = set_nz(cur.p, cur.y + 8'd1);
			end
			OP_DEX: begin
				nxt.x = cur.x - 8'd1;
				nxt.p = set_nz(cur.p, cur.x - 8'd1);
			end
			OP_DEY: begin
				nxt.y = cur.y - 8'd1;
				nxt.p = set_nz(cur.p, cur.y - 8'd1);
			end
			OP_LDA, OP_PLA: begin
				nxt.a = m;
				nxt.p = set_nz(cur.p, m);
				if (kind_t'(kind) == OP_PLA) begin
					nxt.sp = cur.sp + 8'd1;
				end
			end
			OP_LDX: begin
				nxt.x = m;
				nxt.p = set_nz(cur.p, m);
			end
			OP_LDY: begin
				nxt.y = m;
				nxt.p = set_nz(cur.p, m);
			end
			OP_STA: begin
				res.write_data = a;
				res.write_enable = 1'b1;
			end
			OP_STX: begin
				res.write_data = cur.x;
				res.write_enable = 1'b1;
			end
			OP_STY: begin
				res.write_data = cur.y;
				res.write_enable = 1'b1;
			end
			OP_TAX: begin
				nxt.x = a;
				nxt.p = set_nz(cur.p, a);
			end
			OP_TAY: begin
				nxt.y = a;
				nxt.p = set_nz(cur.p, a);
			end
			OP_TXA: begin
				nxt.a = cur.x;
				nxt.p = set_nz(cur.p, cur.x);
			end
			OP_TYA: begin
				nxt.a = cur.y;
				nxt.p = set_nz(cur.p, cur.y);
			end
			OP_TSX: begin
				nxt.x = cur.sp;
				nxt.p = set_nz(cur.p, cur.sp);
			end
			OP_TXS: nxt.sp = cur.x;
			OP_CLC: nxt.p[FL_C] = 1'b0;
			OP_CLD: nxt.p[FL_D] = 1'b0;
			OP_CLI: nxt.p[FL_I] = 1'b0;
			OP_CLV: nxt.p[FL_V] = 1'b0;
			OP_SEC: nxt.p[FL_C] = 1'b1;
			OP_SED: nxt.p[FL_D] = 1'b1;
			OP_SEI: nxt.p[FL_I] = 1'b1;
			OP_PHA: begin
				res.write_data = a;
				res.write_enable = 1'b1;
				nxt.sp = cur.sp - 8'd1;
			end
			OP_PHP, OP_BRK: begin
				res.write_data = cur.p;
				res.write_data[FL_B] = 1'b1;
				res.write_data[FL_U] = 1'b1;
				res.write_enable = 1'b1;
				nxt.sp = cur.sp - 8'd1;
				if (kind_t'(kind) == OP_BRK) begin
					nxt.p[FL_B] = 1'b1;
					nxt.p[FL_I] = 1'b1;
				end
			end
			OP_PLP: begin
				nxt.sp = cur.sp + 8'd1;
				nxt.p = m;
				nxt.p[FL_U] = 1'b0;
			end
			OP_BCC: res.branch_taken = ~cur.p[FL_C];
			OP_BCS: res.branch_taken = cur.p[FL_C];
			OP_BEQ: res.branch_taken = cur.p[FL_Z];
			OP_BMI: res.branch_taken = cur.p[FL_N];
			OP_BNE: res.branch_taken = ~cur.p[FL_Z];
			OP_BPL: res.branch_taken = ~cur.p[FL_N];
			OP_BVC: res.branch_taken = ~cur.p[FL_V];
			OP_BVS: res.branch_taken = cur.p[FL_V];
			OP_NOP: ;
			default: res.invalid_op = 1'b1;
		endcase
	end

endmodule

[src/cpu8_execute_unit_core.sv]
// channel | dir | tdata (low bit up)                                  | tuser
// s_*     | in  | [7:0] operand                                       | [5:0] kind, [6] on_memory
// m_*     | out | [7:0] write_data, [8] write_enable, [9] branch_taken, | -
//         |     | [17:10] status_out, [25:18] acc_out,                |
//         |     | [33:26] index_x_out, [41:34] index_y_out,           |
//         |     | [49:42] stack_ptr_out, [50] invalid_op, [55:51] 0   |
//
// The result passes through the input register, then the result register, before it
// appears on m_tvalid. One item per cycle sustained while m_tready stays high: the
// input register executes against A/X/Y/SP/P in one pass and writes both the
// registers and the result register.
// arst_n clears the architectural registers (A, X, Y, SP, P = 0) and both valid flags.
// A stalled result holds the input register; s_tready drops only while both
// the input register and the result register are full and m_tready is low.
module cpu8_execute_unit_core import cpu8eu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] operand
	input  logic [IN_USER_W-1:0]  s_tuser,   // [5:0] kind, [6] on_memory
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// write_data, write_enable, branch_taken, status_out, acc_out,
	// index_x_out, index_y_out, stack_ptr_out, invalid_op, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata
);

	// input register
	logic              valid_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [BYTE_W-1:0] operand_s1;
	logic              on_memory_s1;

	// architectural registers and result register
	state_t                state_q, state_nxt;
	result_t               res_nxt;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic advance;

	// the item in the input register retires when the result slot is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1      <= s_tuser[KIND_W-1:0];
			on_memory_s1 <= s_tuser[KIND_W];
			operand_s1   <= s_tdata;
		end
	end

	cpu8eu_datapath u_datapath (
		.kind      (kind_s1),
		.operand   (operand_s1),
		.on_memory (on_memory_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// registers commit only when the item retires, so the next item sees them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {5'd0, res_nxt.invalid_op, state_nxt.sp, state_nxt.y,
				state_nxt.x, state_nxt.a, state_nxt.p, res_nxt.branch_taken,
				res_nxt.write_enable, res_nxt.write_data};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// a stalled result freezes the architectural registers
	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(state_q))
		else $error("state changed while result stalled");

	// the presented register fields match the committed registers
	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (m_tdata[25:18] == state_q.a && m_tdata[49:42] == state_q.sp))
		else $error("result registers differ from state");

	// bit 5 of the status register is never set
	a_status_u_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.p[FL_U])
		else $error("status bit 5 set");

	// invalid ops neither write nor branch; write data is zero when not written
	a_invalid_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((!m_tdata[50] || (!m_tdata[8] && !m_tdata[9]))
			&& (m_tdata[8] || m_tdata[7:0] == '0)))
		else $error("invalid op or idle write carried side effects");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import cpu8eu_pkg::*;

	// first undefined code; everything from here up to all ones must flag invalid_op
	localparam logic [KIND_W-1:0] KIND_UNDEF_LO = OP_NOP + 6'd1;
	localparam logic [KIND_W-1:0] KIND_UNDEF_HI = '1;

	// one pending operation as it goes onto the slave stream
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] operand;
		logic              on_memory;
	} exec_op_t;

	// everything one result transfer carries
	typedef struct {
		logic [BYTE_W-1:0] wdata;
		logic              wen;
		logic              taken;
		logic [BYTE_W-1:0] flags;
		logic [BYTE_W-1:0] acc;
		logic [BYTE_W-1:0] ix;
		logic [BYTE_W-1:0] iy;
		logic [BYTE_W-1:0] sp;
		logic              bad;
	} exec_result_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// predicted architectural registers (A, X, Y, SP, P)
	logic [BYTE_W-1:0] reg_a, reg_x, reg_y, reg_sp, reg_p;

	exec_op_t     pending_ops[$];
	exec_result_t expected_results[$];
	int           mismatch_count = 0;
	int           results_seen = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;

	logic [BYTE_W-1:0] corner_bytes [6] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h99, 8'h0F};

	cpu8_execute_unit_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop well past the slowest legal run (~1200 items, heavy stalls)
	initial begin
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic void update_nz(logic [BYTE_W-1:0] v);
		reg_p[FL_Z] = (v == '0);
		reg_p[FL_N] = v[7];
	endfunction

	// Executes one operation on the predicted registers and returns the result transfer.
	function automatic exec_result_t exec_step(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] opnd,
			logic on_mem);
		exec_result_t      res;
		int unsigned       a, m, c, bin, lo, hi, t, nm, r, borrow, lb;
		logic [BYTE_W-1:0] src, val;
		logic              carry_in;
		res = '{default: '0};
		a = reg_a;
		m = opnd;
		case (kind)
			OP_ADC: begin
				c = reg_p[FL_C];
				bin = a + m + c;
				reg_p[FL_C] = 1'b0;
				reg_p[FL_V] = 1'b0;
				reg_p[FL_N] = 1'b0;
				// Z always from the binary sum, even in decimal mode
				reg_p[FL_Z] = ((bin & 255) == 0);
				if (reg_p[FL_D]) begin
					lo = (a & 15) + (m & 15) + c;
					if (lo > 9) lo += 6;
					hi = (a >> 4) + (m >> 4) + ((lo > 15) ? 1 : 0);
					// N and V are taken after the low-nibble fix only
					t = ((hi << 4) | (lo & 15)) & 255;
					reg_p[FL_N] = t[7];
					reg_p[FL_V] = ((~(a ^ m) & (a ^ t) & 128) != 0);
					if (hi > 9) hi += 6;
					reg_p[FL_C] = (hi > 15);
					reg_a = BYTE_W'((hi << 4) | (lo & 15));
				end else begin
					r = bin & 255;
					reg_p[FL_C] = (bin > 255);
					reg_p[FL_V] = ((~(a ^ m) & (a ^ r) & 128) != 0);
					reg_p[FL_N] = r[7];
					reg_a = r[BYTE_W-1:0];
				end
			end
			OP_SBC: begin
				borrow = reg_p[FL_C] ? 0 : 1;
				nm = ~m & 255;
				bin = a + nm + (1 - borrow);
				r = bin & 255;
				// every flag comes from the binary difference
				reg_p[FL_C] = (bin > 255);
				reg_p[FL_Z] = (r == 0);
				reg_p[FL_V] = ((~(a ^ nm) & (a ^ r) & 128) != 0);
				reg_p[FL_N] = r[7];
				if (reg_p[FL_D]) begin
					lo = ((a & 15) - (m & 15) - borrow) & 16'hFFFF;
					lb = (lo & 16) ? 1 : 0;
					if (lb) lo -= 6;
					hi = ((a >> 4) - (m >> 4) - lb) & 16'hFFFF;
					if (hi & 16) hi -= 6;
					r = ((hi << 4) | (lo & 15)) & 255;
				end
				reg_a = r[BYTE_W-1:0];
			end
			OP_AND: begin reg_a = reg_a & opnd; update_nz(reg_a); end
			OP_ORA: begin reg_a = reg_a | opnd; update_nz(reg_a); end
			OP_EOR: begin reg_a = reg_a ^ opnd; update_nz(reg_a); end
			OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
				src = on_mem ? opnd : reg_a;
				carry_in = reg_p[FL_C];
				if (kind == OP_ASL || kind == OP_ROL) begin
					reg_p[FL_C] = src[7];
					val = {src[6:0], (kind == OP_ROL) ? carry_in : 1'b0};
				end else begin
					// LSR/ROR carry out of bit 0
					reg_p[FL_C] = src[0];
					val = {(kind == OP_ROR) ? carry_in : 1'b0, src[7:1]};
				end
				update_nz(val);
				if (on_mem) begin
					res.wdata = val;
					res.wen = 1'b1;
				end else
					reg_a = val;
			end
			OP_CMP, OP_CPX, OP_CPY: begin
				src = (kind == OP_CMP) ? reg_a : (kind == OP_CPX) ? reg_x : reg_y;
				val = src - opnd;
				reg_p[FL_C] = (src >= opnd);
				reg_p[FL_Z] = (src == opnd);
				reg_p[FL_N] = val[7];
			end
			OP_BIT: begin
				reg_p[FL_Z] = ((reg_a & opnd) == '0);
				reg_p[FL_V] = opnd[6];
				reg_p[FL_N] = opnd[7];
			end
			OP_INC, OP_DEC: begin
				// on_memory low means the accumulator form
				src = on_mem ? opnd : reg_a;
				val = src + ((kind == OP_INC) ? 8'h01 : 8'hFF);
				update_nz(val);
				if (on_mem) begin
					res.wdata = val;
					res.wen = 1'b1;
				end else
					reg_a = val;
			end
			OP_INX: begin reg_x = reg_x + 8'h01; update_nz(reg_x); end
			OP_INY: begin reg_y = reg_y + 8'h01; update_nz(reg_y); end
			OP_DEX: begin reg_x = reg_x - 8'h01; update_nz(reg_x); end
			OP_DEY: begin reg_y = reg_y - 8'h01; update_nz(reg_y); end
			OP_LDA: begin reg_a = opnd; update_nz(reg_a); end
			OP_LDX: begin reg_x = opnd; update_nz(reg_x); end
			OP_LDY: begin reg_y = opnd; update_nz(reg_y); end
			OP_STA: begin res.wdata = reg_a; res.wen = 1'b1; end
			OP_STX: begin res.wdata = reg_x; res.wen = 1'b1; end
			OP_STY: begin res.wdata = reg_y; res.wen = 1'b1; end
			OP_TAX: begin reg_x = reg_a; update_nz(reg_x); end
			OP_TAY: begin reg_y = reg_a; update_nz(reg_y); end
			OP_TXA: begin reg_a = reg_x; update_nz(reg_a); end
			OP_TYA: begin reg_a = reg_y; update_nz(reg_a); end
			OP_TSX: begin reg_x = reg_sp; update_nz(reg_x); end
			OP_TXS: reg_sp = reg_x;
			OP_CLC: reg_p[FL_C] = 1'b0;
			OP_CLD: reg_p[FL_D] = 1'b0;
			OP_CLI: reg_p[FL_I] = 1'b0;
			OP_CLV: reg_p[FL_V] = 1'b0;
			OP_SEC: reg_p[FL_C] = 1'b1;
			OP_SED: reg_p[FL_D] = 1'b1;
			OP_SEI: reg_p[FL_I] = 1'b1;
			OP_PHA, OP_PHP, OP_BRK: begin
				// push at SP, then post-decrement; status goes out with B and bit 5 set
				val = reg_p;
				val[FL_B] = 1'b1;
				val[FL_U] = 1'b1;
				res.wdata = (kind == OP_PHA) ? reg_a : val;
				res.wen = 1'b1;
				reg_sp = reg_sp - 8'h01;
				if (kind == OP_BRK) begin
					reg_p[FL_B] = 1'b1;
					reg_p[FL_I] = 1'b1;
				end
			end
			OP_PLA, OP_PLP: begin
				reg_sp = reg_sp + 8'h01;
				if (kind == OP_PLA) begin
					reg_a = opnd;
					update_nz(reg_a);
				end else begin
					reg_p = opnd;
					reg_p[FL_U] = 1'b0;
				end
			end
			OP_BCC: res.taken = ~reg_p[FL_C];
			OP_BCS: res.taken = reg_p[FL_C];
			OP_BEQ: res.taken = reg_p[FL_Z];
			OP_BMI: res.taken = reg_p[FL_N];
			OP_BNE: res.taken = ~reg_p[FL_Z];
			OP_BPL: res.taken = ~reg_p[FL_N];
			OP_BVC: res.taken = ~reg_p[FL_V];
			OP_BVS: res.taken = reg_p[FL_V];
			OP_NOP: ;
			default: res.bad = 1'b1;
		endcase
		res.flags = reg_p;
		res.acc = reg_a;
		res.ix = reg_x;
		res.iy = reg_y;
		res.sp = reg_sp;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
		mismatch_count++;
		$display("ERROR: result %0d %s: got %02h, expected %02h", results_seen, what, got,
			want);
	endtask

	task automatic queue_op(kind_t kind, logic [BYTE_W-1:0] opnd, logic on_mem);
		pending_ops.push_back('{kind: kind, operand: opnd, on_memory: on_mem});
	endtask

	// sender holds off until the stream is empty and every result is back
	task automatic drain();
		while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Driver: predict on every accepted transfer, then offer the next item or idle.
	always @(posedge clk or negedge arst_n) begin : driver
		exec_op_t next_op;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			reg_a = '0;
			reg_x = '0;
			reg_y = '0;
			reg_sp = '0;
			reg_p = '0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(exec_step(s_tuser[KIND_W-1:0], s_tdata,
					s_tuser[KIND_W]));
			if (!s_tvalid || s_tready) begin
				if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_op = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_op.operand;
					s_tuser <= {next_op.on_memory, next_op.kind};
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: check each result transfer against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : monitor
		exec_result_t want;
		if (!arst_n)
			m_tready <= 1'b0;
		else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0)
					report_mismatch("unexpected transfer, acc", m_tdata[25:18], '0);
				else begin
					want = expected_results.pop_front();
					if (m_tdata[7:0] !== want.wdata)
						report_mismatch("write_data", m_tdata[7:0], want.wdata);
					if (m_tdata[8] !== want.wen)
						report_mismatch("write_enable", m_tdata[8], want.wen);
					if (m_tdata[9] !== want.taken)
						report_mismatch("branch_taken", m_tdata[9], want.taken);
					if (m_tdata[17:10] !== want.flags)
						report_mismatch("status_out", m_tdata[17:10], want.flags);
					if (m_tdata[25:18] !== want.acc)
						report_mismatch("acc_out", m_tdata[25:18], want.acc);
					if (m_tdata[33:26] !== want.ix)
						report_mismatch("index_x_out", m_tdata[33:26], want.ix);
					if (m_tdata[41:34] !== want.iy)
						report_mismatch("index_y_out", m_tdata[41:34], want.iy);
					if (m_tdata[49:42] !== want.sp)
						report_mismatch("stack_ptr_out", m_tdata[49:42], want.sp);
					if (m_tdata[50] !== want.bad)
						report_mismatch("invalid_op", m_tdata[50], want.bad);
				end
				results_seen++;
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Stimulus: directed corner cases, then three random phases with different backpressure.
	initial begin : stimulus
		exec_op_t    op;
		int unsigned pick;
		send_idle_pct = 16;
		recv_idle_pct = 59;

		// directed: extremes, decimal arithmetic, stack wrap, BRK/PHP/PLP, RMW forms
		queue_op(OP_LDA, 8'hFF, 1'b1);     // N set; on_memory ignored
		queue_op(OP_ADC, 8'h01, 1'b1);     // binary wrap to zero, C and Z
		queue_op(OP_SED, 8'h00, 1'b0);
		queue_op(OP_LDA, 8'h58, 1'b0);
		queue_op(OP_ADC, 8'h46, 1'b0);     // decimal 58+46+1 with carry out
		queue_op(OP_ADC, 8'hFF, 1'b0);     // decimal with non-BCD digits
		queue_op(OP_SBC, 8'h00, 1'b0);
		queue_op(OP_SBC, 8'hFA, 1'b0);     // decimal borrow through non-BCD digit
		queue_op(OP_PHA, 8'h00, 1'b0);     // SP 00 -> FF
		queue_op(OP_PHP, 8'h00, 1'b0);     // status pushed with B and bit 5
		queue_op(OP_BRK, 8'h00, 1'b0);     // push, then set B and I
		queue_op(OP_PLP, 8'hFF, 1'b0);     // bit 5 must come back cleared
		queue_op(OP_BVS, 8'h80, 1'b0);
		queue_op(OP_CLD, 8'h00, 1'b0);
		queue_op(OP_PLA, 8'h80, 1'b0);
		queue_op(OP_PLA, 8'h00, 1'b0);     // SP FF -> 00
		queue_op(OP_INC, 8'h7F, 1'b0);     // accumulator form
		queue_op(OP_DEC, 8'h00, 1'b1);     // memory form, wraps to FF
		queue_op(OP_LSR, 8'h01, 1'b1);     // carry from bit 0
		queue_op(OP_ROR, 8'h00, 1'b0);
		queue_op(OP_BIT, 8'hC0, 1'b0);     // V and N straight from memory
		queue_op(OP_TXS, 8'h00, 1'b0);
		queue_op(OP_CPX, 8'hFF, 1'b0);
		queue_op(kind_t'(KIND_UNDEF_HI), 8'hFF, 1'b1);
		queue_op(kind_t'(KIND_UNDEF_LO), 8'h00, 1'b0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sender sits idle here until the directed part has fully drained
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 59 : 0;
			recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 16 : 0;
			for (int i = 0; i < 384; i++) begin
				pick = $urandom_range(99);
				// lean on ADC/SBC so both arithmetic modes see plenty of traffic
				if (pick < 25)
					op.kind = $urandom_range(1) ? OP_SBC : OP_ADC;
				else if (pick < 31)
					op.kind = KIND_W'($urandom_range(KIND_UNDEF_HI, KIND_UNDEF_LO));
				else
					op.kind = KIND_W'($urandom_range(OP_NOP, OP_ADC));
				op.operand = ($urandom_range(4) == 0) ? corner_bytes[$urandom_range(5)]
					: BYTE_W'($urandom_range(255));
				op.on_memory = 1'($urandom_range(1));
				pending_ops.push_back(op);
			end
			drain();
		end

		// let anything stray show up on the master side before the verdict
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
